>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion wrappers, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/mrfct_pkg.sv
// ----------------------------------------------------------------------------
// mrfct_pkg
// types and constants for the masked register file with copy trigger
// ----------------------------------------------------------------------------
package mrfct_pkg;

   localparam int unsigned IDX_W  = 8;
   localparam int unsigned DATA_W = 24;

   localparam logic [DATA_W-1:0] ALL_ONES = 24'hFF_FFFF;

   // register indexes with a special role
   localparam logic [IDX_W-1:0] IDX_MASK_LOAD = 8'hFE;
   localparam logic [IDX_W-1:0] IDX_TRIGGER   = 8'h52;

   // copy bank: entries 0x49 to 0x54 are kept; all but 0x4C and 0x52 feed the descriptor
   localparam logic [IDX_W-1:0] BANK_BASE = 8'h49;
   localparam logic [IDX_W-1:0] BANK_LAST = 8'h54;
   localparam int unsigned BANK_DEPTH = 12;
   localparam int unsigned BANK_AW    = 4;

   localparam logic [BANK_AW-1:0] OFF_SRC    = BANK_AW'(8'h49 - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_DIM    = BANK_AW'(8'h4A - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_DEST   = BANK_AW'(8'h4B - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_SECOND = BANK_AW'(8'h4D - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_STRIDE = BANK_AW'(8'h4E - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_CLR_AR = BANK_AW'(8'h4F - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_CLR_GB = BANK_AW'(8'h50 - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_DEPTH  = BANK_AW'(8'h51 - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_FILT_LO = BANK_AW'(8'h53 - BANK_BASE);
   localparam logic [BANK_AW-1:0] OFF_FILT_HI = BANK_AW'(8'h54 - BANK_BASE);

   // configuration register indexes
   localparam logic CSR_COPY_OUTPUT_ENABLE = 1'b0;

   typedef logic [BANK_DEPTH-1:0][DATA_W-1:0] bank_type;

   typedef struct packed {
      logic [7:0]  reg_index;
      logic [23:0] write_value;
   } req_type;

   typedef struct packed {
      logic [9:0]  src_upper;
      logic [9:0]  src_lower;
      logic [10:0] size_upper;
      logic [10:0] size_lower;
      logic [28:0] dest_address;
      logic [28:0] second_address;
      logic [23:0] dest_stride_word;
      logic [7:0]  format_fields;
      logic [41:0] filter_coeffs;
      logic [31:0] clear_argb;
      logic [23:0] clear_depth;
      logic [7:0]  copy_flags;
   } rsp_type;

endpackage

>>> hw/rtl/mrfct_copy_decode.sv
// ----------------------------------------------------------------------------
// mrfct_copy_decode
// unpacks the copy bank and the control word into one copy descriptor
// ----------------------------------------------------------------------------
module mrfct_copy_decode
   import mrfct_pkg::*;
(
   input  bank_type          bank,
   input  logic [DATA_W-1:0] ctl,
   output rsp_type           desc
);

   logic [DATA_W-1:0] src;
   logic [DATA_W-1:0] dim;
   logic [DATA_W-1:0] c4f;
   logic [DATA_W-1:0] c50;

   always_comb begin
      src = bank[OFF_SRC];
      dim = bank[OFF_DIM];
      c4f = bank[OFF_CLR_AR];
      c50 = bank[OFF_CLR_GB];

      desc.src_upper        = src[19:10];
      desc.src_lower        = src[9:0];
      desc.size_upper       = {1'b0, dim[19:10]} + 11'd1;
      desc.size_lower       = {1'b0, dim[9:0]} + 11'd1;
      desc.dest_address     = {bank[OFF_DEST], 5'b0_0000};
      desc.second_address   = {bank[OFF_SECOND], 5'b0_0000};
      desc.dest_stride_word = bank[OFF_STRIDE];
      desc.format_fields    = {ctl[13:12], ctl[8:7], ctl[6:3]};
      desc.filter_coeffs    = {bank[OFF_FILT_HI][17:0], bank[OFF_FILT_LO]};
      desc.clear_argb       = {c4f[15:8], c50[7:0], c50[15:8], c4f[7:0]};
      desc.clear_depth      = bank[OFF_DEPTH];
      desc.copy_flags       = {ctl[16], ctl[15], ctl[14], ctl[11],
                               ctl[10], ctl[9], ctl[1], ctl[0]};
   end

endmodule

>>> hw/rtl/masked_register_file_copy_trigger.sv
// ----------------------------------------------------------------------------
// masked_register_file_copy_trigger
// masked register writes with a one-shot mask and a copy descriptor trigger
// ----------------------------------------------------------------------------
//
//   channel  | direction | payload   | handshake
//   ---------+-----------+-----------+------------------------------
//   req      | in        | req_type  | req_valid / req_stall
//   rsp      | out       | rsp_type  | rsp_valid / rsp_stall
//   csr      | in        | 32-bit    | apb-style, pready tied high
//
// one item per cycle sustained while no trigger waits; an item passes through the
// input register and its descriptor is then registered in the output register
// the read-modify-write of the copy bank and the mask happens as the item
// leaves the input register, so a following item sees it straight away
// reset clears the mask to all ones, the bank to zeros and enables output
// a trigger item waits in the input register only while the output register
// is full and stalled; items that give no descriptor never wait
//
module masked_register_file_copy_trigger
   import mrfct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "assert_macros.svh"

   // only entries 0x49 to 0x54 are ever visible at the outputs, so just that
   // bank is kept; writes elsewhere still consume the one-shot mask
   bank_type          bank_ff;
   logic [DATA_W-1:0] mask_ff;
   logic              enable_ff;

   // input register
   logic              s1_valid_ff;
   req_type           s1_data_ff;

   // output register
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              csr_write;
   logic              s1_in_bank;
   logic [BANK_AW-1:0] s1_off;
   logic [DATA_W-1:0] old_value;
   logic [DATA_W-1:0] merged_value;
   logic              s1_mask_load;
   logic              s1_emit;
   logic              out_free;
   logic              s1_fire;
   logic              req_accept;
   logic              s1_valid_in;
   logic              rsp_valid_in;
   rsp_type           desc;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_COPY_OUTPUT_ENABLE) ?
                       {31'b0, enable_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_write && csr_paddr[2] == CSR_COPY_OUTPUT_ENABLE) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   // merge of the item held in the input register
   always_comb begin
      s1_in_bank   = (s1_data_ff.reg_index >= BANK_BASE) &&
                     (s1_data_ff.reg_index <= BANK_LAST);
      s1_off       = BANK_AW'(s1_data_ff.reg_index - BANK_BASE);
      old_value    = s1_in_bank ? bank_ff[s1_off] : '0;
      merged_value = (old_value & ~mask_ff) | (s1_data_ff.write_value & mask_ff);
      s1_mask_load = (s1_data_ff.reg_index == IDX_MASK_LOAD);
      s1_emit      = (s1_data_ff.reg_index == IDX_TRIGGER) && enable_ff;
   end

   // flow control: the output register takes a new item when empty or draining
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && (!s1_emit || out_free);
   assign req_stall    = s1_valid_ff && !s1_fire;
   assign req_accept   = req_valid && !req_stall;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = out_free ? (s1_fire && s1_emit) : rsp_valid_ff;

   // descriptor decode; the control word is the merged trigger value
   mrfct_copy_decode u_decode (
      .bank (bank_ff),
      .ctl  (merged_value),
      .desc (desc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
   end

   // copy bank and one-shot mask
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= '0;
         mask_ff <= ALL_ONES;
      end else if (s1_fire) begin
         if (s1_mask_load) begin
            mask_ff <= s1_data_ff.write_value;
         end else begin
            mask_ff <= ALL_ONES;
            if (s1_in_bank) begin
               bank_ff[s1_off] <= merged_value;
            end
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_fire && s1_emit) begin
         rsp_data_ff <= desc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a trigger leaving the input register always lands in the output register
   `ASSERT_NEXT(a_trigger_lands, clock, reset, s1_fire && s1_emit, rsp_valid_ff)
   // the mask is one-shot: any merged write restores it
   `ASSERT_NEXT(a_mask_restored, clock, reset, s1_fire && !s1_mask_load, mask_ff == ALL_ONES)
   // the input side only stalls while a trigger waits for the output register
   `ASSERT_IMPLIES(a_stall_cause, clock, reset, req_stall, s1_valid_ff && s1_emit && !out_free)
   // sizes are always one more than a ten-bit field
   `ASSERT_IMPLIES(a_size_nonzero, clock, reset, rsp_valid_ff, rsp_data_ff.size_upper != 11'd0 && rsp_data_ff.size_lower != 11'd0)

endmodule
